@@ design/nndg_pkg.sv @@
`timescale 1ns / 1ps
package nndg_pkg;

  localparam int BASE_W   = 3;
  localparam int CFG_W    = 11;
  localparam int POS_W    = 32;
  localparam int ENERGY_W = 19;
  localparam int ENTRY_W  = 9;

  localparam logic [ENERGY_W-1:0] ENERGY_MAX = '1;
  localparam logic [CFG_W-1:0]    WIN_RESET  = 11'd100;
  localparam logic [CFG_W-1:0]    STEP_RESET = 11'd10;

  localparam logic [BASE_W-1:0] BASE_T = 3'd3;
  localparam logic [BASE_W-1:0] BASE_N = 3'd4;

  typedef enum logic [1:0] {
    REG_LIBRARY  = 2'd0,
    REG_WINDOW   = 2'd1,
    REG_STEP     = 2'd2,
    REG_GRADIENT = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic start;
    logic lib;
    logic gradient;
  } scan_ctl_t;

  // stacking energies in hundredths, row = library, column = {first, second} base
  localparam logic [ENTRY_W-1:0] NN_TABLE [2][16] = '{
    '{9'd102, 9'd143, 9'd116, 9'd73,  9'd138, 9'd177, 9'd209, 9'd116,
      9'd146, 9'd228, 9'd177, 9'd143, 9'd60,  9'd146, 9'd138, 9'd102},
    '{9'd190, 9'd130, 9'd160, 9'd150, 9'd190, 9'd310, 9'd360, 9'd160,
      9'd160, 9'd310, 9'd310, 9'd130, 9'd90,  9'd160, 9'd190, 9'd190}
  };

  function automatic logic [ENTRY_W-1:0] nn_energy(input logic lib,
                                                   input logic [1:0] a,
                                                   input logic [1:0] b);
    return NN_TABLE[lib][{a, b}];
  endfunction

  function automatic logic [ENERGY_W-1:0] sat_energy(input logic [63:0] x);
    logic [ENERGY_W-1:0] r;
    if (x > 64'(ENERGY_MAX)) r = ENERGY_MAX;
    else r = ENERGY_W'(x);
    return r;
  endfunction

endpackage

@@ design/nndg_ring.sv @@
`timescale 1ns / 1ps
module nndg_ring import nndg_pkg::*; #(
  parameter int MAX_WINDOW = 1024
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1)-1:0] waddr,
  input  logic [BASE_W-1:0]                            wdata,
  input  logic                                         re,
  input  logic [((MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1)-1:0] raddr,
  output logic [BASE_W-1:0]                            rdata
);

  logic [BASE_W-1:0] mem [MAX_WINDOW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/nndg_acc.sv @@
`timescale 1ns / 1ps
module nndg_acc import nndg_pkg::*; #(
  parameter int MAX_WINDOW = 1024
) (
  input  logic                                                   clk,
  input  logic                                                   rst,
  input  scan_ctl_t                                              ctl,
  input  logic [$clog2(MAX_WINDOW + 1)-1:0]                      win,
  input  logic [((MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1)-1:0] end_ptr,
  output logic                                                   rd_en,
  output logic [((MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1)-1:0] rd_addr,
  input  logic [BASE_W-1:0]                                      rd_data,
  output logic                                                   busy,
  output logic                                                   done,
  output logic [2*$clog2(MAX_WINDOW + 1)+9-1:0]                  sum
);

  localparam int AW     = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int WIN_W  = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W  = 2*WIN_W + 9;
  localparam int PROD_W = ENTRY_W + WIN_W;

  logic              issuing;
  logic [WIN_W-1:0]  issue_cnt;
  logic              rvalid;
  logic [WIN_W-1:0]  k_d;
  logic              lib_q;
  logic              grad_q;
  logic [WIN_W-1:0]  win_q;
  logic [BASE_W-1:0] prev;
  logic              p1, last1, p2, last2;
  logic [ENTRY_W-1:0] e1;
  logic [WIN_W-1:0]  w1;
  logic [PROD_W-1:0] prod;

  logic [WIN_W-1:0]  wm1;
  logic              ptr_ge;
  logic [AW:0]       start_ext;
  logic [AW-1:0]     start_idx;
  logic [WIN_W-1:0]  s_idx, mid, weight;
  logic [ENTRY_W-1:0] energy;

  // oldest base of the window sits win-1 entries behind the newest one
  always_comb begin
    wm1       = win - WIN_W'(1);
    ptr_ge    = (AW + 1)'(end_ptr) >= (AW + 1)'(wm1);
    start_ext = (AW + 1)'(end_ptr) + (ptr_ge ? '0 : (AW + 1)'(MAX_WINDOW)) - (AW + 1)'(wm1);
    start_idx = start_ext[AW-1:0];
  end

  always_comb begin
    s_idx  = k_d - WIN_W'(1);
    mid    = (win_q >> 1) - WIN_W'(1);
    weight = (s_idx <= mid) ? s_idx + WIN_W'(1) : ((mid << 1) + WIN_W'(1)) - s_idx;
    if (prev > BASE_T || rd_data > BASE_T) energy = '0;
    else energy = nn_energy(lib_q, prev[1:0], rd_data[1:0]);
  end

  assign rd_en = issuing;

  always_ff @(posedge clk) begin
    if (rst) begin
      issuing <= 1'b0;
      rvalid  <= 1'b0;
      p1      <= 1'b0;
      p2      <= 1'b0;
      busy    <= 1'b0;
      done    <= 1'b0;
    end else begin
      done   <= 1'b0;
      rvalid <= issuing;
      p1     <= rvalid && (k_d != '0);
      p2     <= p1;
      if (ctl.start) begin
        issuing <= 1'b1;
        busy    <= 1'b1;
      end else if (issuing && issue_cnt == win_q - WIN_W'(1)) begin
        issuing <= 1'b0;
      end
      if (p2 && last2) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      rd_addr   <= start_idx;
      issue_cnt <= '0;
      lib_q     <= ctl.lib;
      grad_q    <= ctl.gradient;
      win_q     <= win;
      sum       <= '0;
    end else begin
      if (issuing) begin
        rd_addr   <= (rd_addr == AW'(MAX_WINDOW - 1)) ? '0 : rd_addr + AW'(1);
        issue_cnt <= issue_cnt + WIN_W'(1);
      end
      if (p2) begin
        sum <= sum + SUM_W'(prod);
      end
    end
    k_d <= issue_cnt;
    if (rvalid) begin
      prev <= rd_data;
    end
    last1 <= rvalid && (k_d == win_q - WIN_W'(1));
    e1    <= energy;
    w1    <= weight;
    last2 <= last1;
    prod  <= grad_q ? PROD_W'(e1) * PROD_W'(w1) : PROD_W'(e1);
  end

endmodule

@@ design/nndg_div.sv @@
`timescale 1ns / 1ps
module nndg_div #(
  parameter int NUM_W = 34,
  parameter int DEN_W = 12
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W:0]   trial;
  logic             ge;

  always_comb begin
    trial = {rem, quo[NUM_W-1]};
    ge    = trial >= {1'b0, den_q};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // restoring division, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      quo   <= num;
      rem   <= '0;
      den_q <= den;
    end else if (busy) begin
      rem <= ge ? DEN_W'(trial - {1'b0, den_q}) : DEN_W'(trial);
      quo <= {quo[NUM_W-2:0], ge};
    end
  end

endmodule

@@ design/nearest_neighbor_dg_window.sv @@
`timescale 1ns / 1ps
// Channel  Direction  Handshake                 Contents
// s_*      in         s_tvalid / s_tready       base word: tdata = base_code, tlast = sequence_end
// m_*      out        m_tvalid / m_tready       result word: centre_position, energy_centi
// p*       in         psel & penable & pwrite   four registers at 0x0, 0x4, 0x8, 0xC
//
// A base that closes no window is taken while the block is idle. A base that closes a clean window
// holds s_tready low until its result word is loaded: the scan reads one base a cycle from the
// single read port of the ring memory. Gradient mode then runs the result through the
// bit-serial divider. Reset is synchronous and clears control state; the ring needs no
// clearing pass. A stalled m_tready holds the result word and stops the next window only.
module nearest_neighbor_dg_window import nndg_pkg::*; #(
  parameter int MAX_WINDOW = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [2:0] base_code, [7:3] zero
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata    // [31:0] centre_position, [50:32] energy_centi, [55:51] zero
);

  localparam int AW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int WIN_W = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W = 2*WIN_W + 9;
  localparam int NUM_W = SUM_W + 3;
  localparam int DEN_W = WIN_W + 1;

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DIV, ST_HOLD} state_t;

  function automatic logic [WIN_W-1:0] sat_win(input logic [CFG_W-1:0] w);
    logic [WIN_W-1:0] r;
    if (w < CFG_W'(2)) r = WIN_W'(2);
    else if (32'(w) > 32'(MAX_WINDOW)) r = WIN_W'(MAX_WINDOW);
    else r = WIN_W'(w);
    return r;
  endfunction

  logic             lib_reg;
  logic [CFG_W-1:0] win_reg;
  logic [CFG_W-1:0] step_reg;
  logic             grad_reg;

  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] next_end;
  logic [POS_W-1:0] n_pos;
  logic             n_valid;
  logic [AW-1:0]    ptr;
  logic [AW-1:0]    ptr_next;

  state_t              state;
  logic [POS_W-1:0]    centre_hold;
  logic [ENERGY_W-1:0] res;
  logic                grad_hold;

  logic [WIN_W-1:0]  eff_win;
  logic [CFG_W-1:0]  eff_step;
  logic [BASE_W-1:0] code;
  logic              s_acc, at_end, n_hit, n_near, win_fire;
  logic [POS_W-1:0]  centre_calc;
  logic              cfg_wr;
  reg_idx_t          reg_idx;
  logic              m_free;

  scan_ctl_t         scan_ctl;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [BASE_W-1:0] rd_data;
  logic              acc_busy, acc_done;
  logic [SUM_W-1:0]  acc_sum;
  logic              div_start, div_busy, div_done;
  logic [NUM_W-1:0]  div_num, div_quo;
  logic [DEN_W-1:0]  div_den;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign reg_idx  = reg_idx_t'(paddr[3:2]);
  assign s_tready = (state == ST_IDLE);
  assign m_free   = !m_tvalid || m_tready;

  always_comb begin
    case (reg_idx)
      REG_LIBRARY:  prdata = 32'(lib_reg);
      REG_WINDOW:   prdata = 32'(win_reg);
      REG_STEP:     prdata = 32'(step_reg);
      REG_GRADIENT: prdata = 32'(grad_reg);
      default:      prdata = '0;
    endcase
  end

  always_comb begin
    eff_win     = sat_win(win_reg);
    eff_step    = (step_reg == '0) ? CFG_W'(1) : step_reg;
    code        = s_tdata[BASE_W-1:0];
    s_acc       = s_tvalid && s_tready;
    at_end      = (pos == next_end);
    n_hit       = (code == BASE_N);
    n_near      = n_valid && ((pos - n_pos) < POS_W'(eff_win));
    win_fire    = s_acc && at_end && !n_hit && !n_near;
    centre_calc = pos + POS_W'(1) - POS_W'(eff_win) + POS_W'(eff_win >> 1)
                  - POS_W'(eff_step >> 1);
    // ring slot follows position modulo depth, including the wrap of the position itself
    if (pos == '1 || ptr == AW'(MAX_WINDOW - 1)) ptr_next = '0;
    else ptr_next = ptr + AW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lib_reg  <= 1'b0;
      win_reg  <= WIN_RESET;
      step_reg <= STEP_RESET;
      grad_reg <= 1'b0;
      pos      <= '0;
      next_end <= POS_W'(sat_win(WIN_RESET)) - POS_W'(1);
      n_pos    <= '0;
      n_valid  <= 1'b0;
      ptr      <= '0;
    end else begin
      if (s_acc) begin
        if (n_hit) begin
          n_pos   <= pos;
          n_valid <= 1'b1;
        end
        if (at_end) begin
          next_end <= pos + POS_W'(eff_step);
        end
        if (s_tlast) begin
          pos      <= '0;
          next_end <= POS_W'(eff_win) - POS_W'(1);
          n_valid  <= 1'b0;
          ptr      <= '0;
        end else begin
          pos <= pos + POS_W'(1);
          ptr <= ptr_next;
        end
      end
      if (cfg_wr) begin
        case (reg_idx)
          REG_LIBRARY:  lib_reg <= pwdata[0];
          REG_WINDOW: begin
            win_reg  <= pwdata[CFG_W-1:0];
            pos      <= '0;
            next_end <= POS_W'(sat_win(pwdata[CFG_W-1:0])) - POS_W'(1);
            n_valid  <= 1'b0;
            ptr      <= '0;
          end
          REG_STEP:     step_reg <= pwdata[CFG_W-1:0];
          REG_GRADIENT: grad_reg <= pwdata[0];
          default: ;
        endcase
      end
    end
  end

  assign scan_ctl.start    = win_fire;
  assign scan_ctl.lib      = lib_reg;
  assign scan_ctl.gradient = grad_reg;

  nndg_ring #(.MAX_WINDOW(MAX_WINDOW)) u_ring (
    .clk   (clk),
    .we    (s_acc),
    .waddr (ptr),
    .wdata (code),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  nndg_acc #(.MAX_WINDOW(MAX_WINDOW)) u_acc (
    .clk     (clk),
    .rst     (rst),
    .ctl     (scan_ctl),
    .win     (eff_win),
    .end_ptr (ptr),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .busy    (acc_busy),
    .done    (acc_done),
    .sum     (acc_sum)
  );

  // 2*S/win rounded half up = (4*S + win) / (2*win)
  assign div_start = (state == ST_SCAN) && acc_done && grad_hold;
  assign div_num   = NUM_W'({acc_sum, 2'b00}) + NUM_W'(eff_win);
  assign div_den   = {eff_win, 1'b0};

  nndg_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (win_fire) begin
            centre_hold <= centre_calc;
            grad_hold   <= grad_reg;
            state       <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (acc_done) begin
            if (grad_hold) begin
              state <= ST_DIV;
            end else begin
              res   <= sat_energy(64'(acc_sum));
              state <= ST_HOLD;
            end
          end
        end
        ST_DIV: begin
          if (div_done) begin
            res   <= sat_energy(64'(div_quo));
            state <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (m_free) begin
            m_tdata  <= {5'b0, res, centre_hold};
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_scan_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (acc_busy || div_busy) |-> !s_tready)
    else $error("input accepted while a window is being summed");

  a_start_on_accept: assert property (@(posedge clk) disable iff (rst)
    scan_ctl.start |-> (s_tvalid && s_tready && at_end))
    else $error("scan started without an accepted window end");

  a_div_gradient_only: assert property (@(posedge clk) disable iff (rst)
    div_start |-> (grad_hold && !div_busy))
    else $error("divider started outside gradient mode or while busy");

  a_hold_loads: assert property (@(posedge clk) disable iff (rst)
    (state == ST_HOLD && m_free) |=> (m_tvalid && state == ST_IDLE))
    else $error("held result not loaded into output register");

endmodule

@@ tb/nearest_neighbor_dg_window_tb.sv @@
`timescale 1ns / 1ps
module nearest_neighbor_dg_window_tb;
  import nndg_pkg::*;

  localparam int MAX_WIN = 1024;
  localparam int LONG_HOLD = 700;
  localparam int SETTLE = 200;
  localparam int RANDOM_BASES = 700;
  localparam int ERR_PRINT_MAX = 40;
  localparam longint CYCLE_LIMIT = 2_000_000;
  localparam longint unsigned ENERGY_CAP = (64'd1 << ENERGY_W) - 1;

  localparam logic [BASE_W-1:0] BASE_A = 3'd0;
  localparam logic [BASE_W-1:0] BASE_C = 3'd1;
  localparam logic [BASE_W-1:0] BASE_G = 3'd2;
  localparam logic [BASE_W-1:0] BASE_X = 3'd5;

  // stacking energies in hundredths, index = {library, first base, second base}
  localparam int unsigned STACK_CENTI [32] = '{
    102, 143, 116, 73,  138, 177, 209, 116, 146, 228, 177, 143, 60, 146, 138, 102,
    190, 130, 160, 150, 190, 310, 360, 160, 160, 310, 310, 130, 90, 160, 190, 190
  };

  // every dinucleotide once, then N and the codes that are no base
  localparam logic [BASE_W-1:0] DIRECTED [21] = '{
    BASE_A, BASE_A, BASE_C, BASE_A, BASE_G, BASE_A, BASE_T, BASE_C, BASE_C, BASE_G,
    BASE_C, BASE_T, BASE_G, BASE_G, BASE_T, BASE_T, BASE_A, BASE_N, BASE_X,
    BASE_X + 3'd1, BASE_X + 3'd2
  };

  typedef struct packed {
    logic [BASE_W-1:0] code;
    logic              seq_end;
  } base_word_t;

  typedef struct packed {
    logic [POS_W-1:0]    centre;
    logic [ENERGY_W-1:0] energy;
  } window_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;   // [2:0] base_code, [7:3] zero
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;        // [31:0] centre_position, [50:32] energy_centi, [55:51] zero

  nearest_neighbor_dg_window #(.MAX_WINDOW(MAX_WIN)) dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  // register shadow, written by the stimulus process only
  logic                lib_sel = 1'b0;
  logic [CFG_W-1:0]    win_reg = WIN_RESET;
  logic [CFG_W-1:0]    step_reg = STEP_RESET;
  logic                grad_sel = 1'b0;
  int unsigned         restart_reqs = 0;

  // sequence state, written by the driver only
  logic [BASE_W-1:0]   seq_ring [MAX_WIN];
  logic [POS_W-1:0]    seq_pos, win_end_pos, n_pos;
  logic                n_valid;
  int unsigned         restart_done = 0;

  base_word_t          pending_q[$];
  window_result_t      expected_q[$];
  base_word_t          cur_base;

  int unsigned queued_bases = 0, accepted_bases = 0, results_checked = 0, error_count = 0;
  int unsigned hold_reqs = 0, hold_served = 0, hold_left = 0, long_holds = 0;
  int unsigned send_gap = 0, recv_gap = 0, phase_count = 0, random_sent = 0;
  logic        send_burst = 1'b0, recv_burst = 1'b0;
  longint      cycle_count = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic int unsigned eff_win();
    int unsigned w;
    w = win_reg;
    if (w < 2) w = 2;
    if (w > MAX_WIN) w = MAX_WIN;
    return w;
  endfunction

  function automatic void restart_seq();
    seq_pos = '0;
    win_end_pos = eff_win() - 1;
    n_pos = '0;
    n_valid = 1'b0;
  endfunction

  function automatic void predict_base(base_word_t w);
    window_result_t    r;
    longint unsigned   acc, e;
    int unsigned       win, stp, mid, wt;
    logic [POS_W-1:0]  start, ia, ib;
    logic [BASE_W-1:0] a, b;
    seq_ring[seq_pos % MAX_WIN] = w.code;
    if (w.code == BASE_N) begin
      n_pos = seq_pos;
      n_valid = 1'b1;
    end
    if (seq_pos == win_end_pos) begin
      win = eff_win();
      stp = (step_reg == 0) ? 1 : step_reg;
      start = seq_pos - win + 1;
      if (!n_valid || (seq_pos - n_pos) >= win) begin
        mid = win / 2 - 1;
        acc = 0;
        for (int unsigned s = 0; s + 1 < win; s++) begin
          ia = start + s;
          ib = ia + 1;
          a = seq_ring[ia % MAX_WIN];
          b = seq_ring[ib % MAX_WIN];
          // codes above T contribute nothing to either neighbor pair
          if (a <= BASE_T && b <= BASE_T) begin
            e = STACK_CENTI[{lib_sel, a[1:0], b[1:0]}];
            if (grad_sel) begin
              wt = (s <= mid) ? s + 1 : 2 * mid + 1 - s;
              e = e * wt;
            end
            acc += e;
          end
        end
        if (grad_sel) acc = (4 * acc + win) / (2 * win);
        r.centre = start + win / 2 - stp / 2;
        r.energy = (acc > ENERGY_CAP) ? ENERGY_CAP[ENERGY_W-1:0] : acc[ENERGY_W-1:0];
        expected_q.push_back(r);
      end
      win_end_pos = seq_pos + stp;
    end
    seq_pos = seq_pos + 1;
    if (w.seq_end) restart_seq();
  endfunction

  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    error_count++;
    if (error_count <= ERR_PRINT_MAX)
      $display("mismatch at %0t: %s expected %0d got %0d", $time, what, want, got);
  endtask

  // base driver
  always @(posedge clk) begin
    logic nxt_valid;
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata <= '0;
      s_tlast <= 1'b0;
      restart_seq();
    end else begin
      // a window register write restarts the sequence before the next base
      if (restart_done != restart_reqs) begin
        restart_seq();
        restart_done = restart_reqs;
      end
      nxt_valid = s_tvalid;
      if (s_tvalid && s_tready) begin
        predict_base(cur_base);
        accepted_bases++;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (send_gap != 0) begin
          send_gap--;
        end else if (pending_q.size() != 0) begin
          cur_base = pending_q.pop_front();
          s_tdata <= {{(8 - BASE_W){1'b0}}, cur_base.code};
          s_tlast <= cur_base.seq_end;
          nxt_valid = 1'b1;
          if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
          send_gap = send_burst ? 0 : $urandom_range(0, 18);
        end
      end
      s_tvalid <= nxt_valid;
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_served != hold_reqs) begin
      hold_served <= hold_reqs;
      hold_left <= LONG_HOLD;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // result monitor
  always @(posedge clk) begin
    window_result_t got, want;
    logic nxt_ready;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.centre = m_tdata[POS_W-1:0];
        got.energy = m_tdata[POS_W +: ENERGY_W];
        if (expected_q.size() == 0) begin
          report_mismatch("result word with no window pending, centre", '0, got.centre);
        end else begin
          want = expected_q.pop_front();
          if (got.centre !== want.centre)
            report_mismatch("centre_position", want.centre, got.centre);
          if (got.energy !== want.energy)
            report_mismatch("energy_centi", 32'(want.energy), 32'(got.energy));
          results_checked++;
        end
        if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
        recv_gap = recv_burst ? 0 : $urandom_range(0, 18);
      end
      if (hold_left != 0) begin
        nxt_ready = 1'b0;
      end else if (recv_gap != 0) begin
        recv_gap--;
        nxt_ready = 1'b0;
      end else begin
        nxt_ready = 1'b1;
      end
      m_tready <= nxt_ready;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d windows outstanding", cycle_count,
               expected_q.size());
      $display("status: fail");
      $finish;
    end
  end

  task automatic wait_drained();
    while (accepted_bases != queued_bases || expected_q.size() != 0) @(posedge clk);
    // a window that holds N adds no expected result; let the block settle before the registers change
    repeat (eff_win() + SETTLE) @(posedge clk);
  endtask

  task automatic apply_reg(reg_idx_t idx, logic [31:0] val);
    logic [31:0] junk, word;
    junk = $urandom();
    // unused upper bits carry noise
    if (idx == REG_LIBRARY || idx == REG_GRADIENT) word = {junk[31:1], val[0]};
    else word = {junk[31:CFG_W], val[CFG_W-1:0]};
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_LIBRARY:  lib_sel = word[0];
      REG_WINDOW: begin
        win_reg = word[CFG_W-1:0];
        restart_reqs++;
      end
      REG_STEP:     step_reg = word[CFG_W-1:0];
      REG_GRADIENT: grad_sel = word[0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic lib, logic [CFG_W-1:0] win, logic [CFG_W-1:0] stp,
                            logic grad, logic write_win);
    wait_drained();
    if (write_win) apply_reg(REG_WINDOW, 32'(win));
    apply_reg(REG_STEP, 32'(stp));
    apply_reg(REG_LIBRARY, 32'(lib));
    apply_reg(REG_GRADIENT, 32'(grad));
    phase_count++;
  endtask

  task automatic push_base(logic [BASE_W-1:0] code, logic seq_end);
    base_word_t w;
    w.code = code;
    w.seq_end = seq_end;
    pending_q.push_back(w);
    queued_bases++;
  endtask

  function automatic logic [BASE_W-1:0] random_base(logic noisy);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (noisy && r < 5) return BASE_N;
    if (r < (noisy ? 12 : 4)) return BASE_W'($urandom_range(BASE_X, 7));
    return BASE_W'($urandom_range(BASE_A, BASE_T));
  endfunction

  task automatic push_sequence(int unsigned len, logic noisy, logic close);
    for (int unsigned i = 0; i < len; i++) push_base(random_base(noisy), close && i == len - 1);
  endtask

  initial begin
    logic [CFG_W-1:0] win, stp;
    int unsigned      ew, es, target, sent, len;
    logic             wr_win;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    set_config(1'b0, 11'd2, 11'd1, 1'b0, 1'b1);
    for (int i = 0; i < 21; i++) push_base(DIRECTED[i], i == 20);

    // window and step below their range
    set_config(1'b1, 11'd0, 11'd0, 1'b1, 1'b1);
    repeat (8) push_sequence($urandom_range(1, 8), 1'b1, 1'b1);

    // tiny window with the widest step: centre wraps below zero
    set_config(1'b0, 11'd1, 11'h7FF, 1'b0, 1'b1);
    repeat (8) push_sequence($urandom_range(1, 5), 1'b0, 1'b1);

    // receiver holds off while bases keep coming
    set_config(1'b0, 11'd3, 11'd1, 1'b1, 1'b1);
    hold_reqs++;
    long_holds++;
    push_sequence(90, 1'b0, 1'b1);

    // widest window, saturated from the top of the register; N drops only the first window
    set_config(1'b1, 11'h7FF, 11'd5, 1'b1, 1'b1);
    for (int i = 0; i < 1040; i++) push_base((i == 3) ? BASE_N : random_base(1'b0), i == 1039);

    // register at exactly the window limit, too few bases to close a window
    set_config(1'b0, 11'd1024, 11'd1024, 1'b0, 1'b1);
    push_sequence(20, 1'b0, 1'b1);

    while (random_sent < RANDOM_BASES) begin
      if ($urandom_range(0, 4) == 0) begin
        win = $urandom_range(100, 260);
        stp = $urandom_range(4, 64);
      end else begin
        win = $urandom_range(2, 40);
        stp = $urandom_range(1, 2 * win + 4);
      end
      // leave the window alone now and then so an open sequence carries on
      wr_win = ($urandom_range(0, 3) != 0) || eff_win() > 300;
      set_config($urandom_range(0, 1), win, stp, $urandom_range(0, 1), wr_win);
      ew = eff_win();
      es = (step_reg == 0) ? 1 : step_reg;
      target = (ew > 60) ? ew + 60 : $urandom_range(40, 80);
      sent = 0;
      while (sent < target) begin
        if ($urandom_range(0, 4) == 0) len = $urandom_range(1, ew);
        else len = $urandom_range(ew, ew + 3 * es);
        push_sequence(len, $urandom_range(0, 9) < 3,
                      (sent + len < target) || $urandom_range(0, 1) == 1);
        sent += len;
      end
      random_sent += sent;
    end

    wait_drained();
    $display("covered %0d register settings and %0d bases, windows 2 to %0d, both tables,",
             phase_count, accepted_bases, MAX_WIN);
    $display("plain and graded sums: %0d window energies checked, %0d long output stalls",
             results_checked, long_holds);
    if (error_count == 0 && expected_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
